### rtl/core/rmedf_pkg.sv
// shared types and constants of the rate monotonic / edf task scheduler
package rmedf_pkg;

  localparam int MAX_TASKS = 16;
  localparam int TICK_BITS = 16;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int NUM_W     = $clog2(MAX_TASKS + 1);
  localparam int VAL_W     = 16;
  localparam int CNT_W     = 16;
  localparam int ABS_W     = TICK_BITS + 1;
  localparam int STEP_W    = $clog2(TICK_BITS + 1);

  localparam logic [TICK_BITS-1:0] TIME_LIMIT = {TICK_BITS{1'b1}};
  localparam logic [CNT_W-1:0]     CNT_MAX    = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_TICK   = 2'd1,
    OP_FINISH = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_BAD_IDX  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CFG_POLICY = 1'b0,
    CFG_COUNT  = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_TICK_SCAN,
    S_PICK,
    S_FIN_SCAN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [TICK_BITS-1:0] dividend;
    logic [VAL_W-1:0]     divisor;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] rem;
  } rem_rsp_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             ran_valid;
    logic [IDX_W-1:0] ran_task;
    logic             job_done;
    logic [NUM_W-1:0] misses_now;
    logic [CNT_W-1:0] completed_count;
    logic [CNT_W-1:0] missed_count;
    logic [CNT_W-1:0] killed_count;
  } res_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

### rtl/core/rmedf_in_if.sv
// input channel of the scheduler: valid, ready and one operation
interface rmedf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [3:0]  task_index;
  logic [15:0] task_period;
  logic [15:0] task_deadline;
  logic [15:0] task_burst;

  modport source (output valid, op, task_index, task_period, task_deadline, task_burst,
                  input ready);
  modport sink   (input valid, op, task_index, task_period, task_deadline, task_burst,
                  output ready);
endinterface

### rtl/core/rmedf_out_if.sv
// result channel of the scheduler: valid, ready and one result
interface rmedf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        ran_valid;
  logic [3:0]  ran_task;
  logic        job_done;
  logic [4:0]  misses_now;
  logic [15:0] completed_count;
  logic [15:0] missed_count;
  logic [15:0] killed_count;

  modport source (output valid, status, ran_valid, ran_task, job_done, misses_now,
                  completed_count, missed_count, killed_count, input ready);
  modport sink   (input valid, status, ran_valid, ran_task, job_done, misses_now,
                  completed_count, missed_count, killed_count, output ready);
endinterface

### rtl/core/rmedf_rem.sv
// restoring remainder unit, one dividend bit per cycle
module rmedf_rem (
  input  logic               clk,
  input  logic               rst_n,
  input  rmedf_pkg::rem_req_t req,
  output rmedf_pkg::rem_rsp_t rsp
);
  import rmedf_pkg::*;

  logic [VAL_W-1:0]     rem_r, rem_nxt;
  logic [TICK_BITS-1:0] dvd_r, dvd_nxt;
  logic [VAL_W-1:0]     dsr_r, dsr_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [VAL_W:0]       trial;

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[TICK_BITS-1]};
    if (req.start) begin
      rem_nxt  = '0;
      dvd_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) trial = trial - {1'b0, dsr_r};
      rem_nxt  = trial[VAL_W-1:0];
      dvd_nxt  = dvd_r << 1;
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(TICK_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;
endmodule

### rtl/core/rm_edf_task_scheduler.sv
// Periodic task scheduler, rate monotonic or earliest deadline first, one time step per tick.
// One operation at a time: a tick walks all MAX_TASKS entries once, one entry per cycle
// (miss check, release and winner search), then the pick state runs the winner. A tick at
// TIME_LIMIT only reports overflow. A finish walks the entries the same way. A valid load
// waits for the bit-serial remainder unit that finds the new task's release phase; a read
// or a rejected item goes straight to the output state.
// A finished result waits in the output register while the next item is accepted.
module rm_edf_task_scheduler (
  input  logic              clk,
  input  logic              rst_n,
  rmedf_in_if.sink          in_ch,
  rmedf_out_if.source       out_ch,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [4:0]        cfg_wdata
);
  import rmedf_pkg::*;

  state_t state_r, state_nxt;

  logic             policy_r;
  logic [NUM_W-1:0] count_r;

  logic [VAL_W-1:0]     period_r  [MAX_TASKS];
  logic [VAL_W-1:0]     reldl_r   [MAX_TASKS];
  logic [VAL_W-1:0]     burst_r   [MAX_TASKS];
  logic [VAL_W-1:0]     phase_r   [MAX_TASKS];
  logic [VAL_W-1:0]     work_r    [MAX_TASKS];
  logic [ABS_W-1:0]     absdl_r   [MAX_TASKS];
  logic [CNT_W-1:0]     done_cnt_r[MAX_TASKS];
  logic [CNT_W-1:0]     miss_cnt_r[MAX_TASKS];
  logic [CNT_W-1:0]     kill_cnt_r[MAX_TASKS];
  logic [TICK_BITS-1:0] time_r;

  logic [IDX_W-1:0] tidx_r;
  logic [VAL_W-1:0] per_r, dl_r, bu_r;

  logic [IDX_W-1:0] idx_r;
  logic             best_vld_r;
  logic [IDX_W-1:0] best_idx_r;
  logic [ABS_W-1:0] best_key_r;
  logic [VAL_W-1:0] best_work_r;
  logic [NUM_W-1:0] misses_r;

  res_t res_r;
  res_t out_res_r;
  logic out_valid_r;

  rem_req_t rem_req;
  rem_rsp_t rem_rsp;

  logic [NUM_W-1:0] n_eff;
  logic             in_xfer, out_free;
  logic             idx_in_use, scan_in_use, scan_last;
  logic             load_ok;

  // per-entry view during a scan
  logic [VAL_W-1:0] s_work;
  logic [ABS_W-1:0] s_abs;
  logic             s_miss, s_rel;
  logic [ABS_W-1:0] s_key;
  logic [VAL_W:0]   s_phase_inc;

  rmedf_rem u_rem (.clk(clk), .rst_n(rst_n), .req(rem_req), .rsp(rem_rsp));

  assign n_eff       = (count_r > NUM_W'(MAX_TASKS)) ? NUM_W'(MAX_TASKS) : count_r;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign idx_in_use  = {1'b0, in_ch.task_index} < n_eff;
  assign scan_in_use = {1'b0, idx_r} < n_eff;
  assign scan_last   = idx_r == IDX_W'(MAX_TASKS - 1);
  assign load_ok     = in_ch.task_period != '0 && in_ch.task_deadline != '0 &&
                       in_ch.task_burst != '0 && in_ch.task_deadline <= in_ch.task_period &&
                       in_ch.task_burst <= in_ch.task_deadline;

  always_comb begin
    s_miss = scan_in_use && work_r[idx_r] != '0 &&
             absdl_r[idx_r] == {1'b0, time_r};
    s_rel  = scan_in_use && period_r[idx_r] != '0 && phase_r[idx_r] == '0;
    s_work = s_miss ? '0 : work_r[idx_r];
    s_abs  = absdl_r[idx_r];
    if (s_rel) begin
      s_work = burst_r[idx_r];
      s_abs  = {1'b0, time_r} + {1'b0, reldl_r[idx_r]};
    end
    s_key       = policy_r ? s_abs : {1'b0, period_r[idx_r]};
    s_phase_inc = {1'b0, phase_r[idx_r]} + 17'd1;
  end

  assign rem_req.start    = state_r == S_IDLE && in_xfer && op_t'(in_ch.op) == OP_LOAD &&
                            idx_in_use && load_ok;
  assign rem_req.dividend = time_r;
  assign rem_req.divisor  = in_ch.task_period;

  assign in_ch.ready = state_r == S_IDLE;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (op_t'(in_ch.op))
            OP_LOAD:   state_nxt = rem_req.start ? S_DIV : S_OUT;
            OP_TICK:   state_nxt = (time_r == TIME_LIMIT) ? S_OUT : S_TICK_SCAN;
            OP_FINISH: state_nxt = S_FIN_SCAN;
            OP_READ:   state_nxt = S_OUT;
            default:   state_nxt = S_OUT;
          endcase
        end
      end
      S_DIV:       if (rem_rsp.done) state_nxt = S_OUT;
      S_TICK_SCAN: if (scan_last) state_nxt = S_PICK;
      S_PICK:      state_nxt = S_OUT;
      S_FIN_SCAN:  if (scan_last) state_nxt = S_OUT;
      S_OUT:       if (out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      policy_r    <= 1'b0;
      count_r     <= NUM_W'(1);
      time_r      <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        work_r[i]     <= '0;
        absdl_r[i]    <= '0;
        done_cnt_r[i] <= '0;
        miss_cnt_r[i] <= '0;
        kill_cnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_POLICY: policy_r <= cfg_wdata[0];
          CFG_COUNT:  count_r  <= cfg_wdata[NUM_W-1:0];
          default:    ;
        endcase
      end
      out_valid_r <= (state_r == S_OUT && out_free) || (out_valid_r && !out_ch.ready);

      unique case (state_r)
        S_IDLE: begin
          idx_r      <= '0;
          best_vld_r <= 1'b0;
          misses_r   <= '0;
          if (in_xfer) begin
            tidx_r <= in_ch.task_index;
            per_r  <= in_ch.task_period;
            dl_r   <= in_ch.task_deadline;
            bu_r   <= in_ch.task_burst;
            res_r.ran_valid  <= 1'b0;
            res_r.ran_task   <= '0;
            res_r.job_done   <= 1'b0;
            res_r.misses_now <= '0;
            unique case (op_t'(in_ch.op))
              OP_LOAD:   res_r.status <= !idx_in_use ? ST_BAD_IDX :
                                         (!load_ok ? ST_INVALID : ST_OK);
              OP_TICK:   res_r.status <= (time_r == TIME_LIMIT) ? ST_OVERFLOW : ST_OK;
              OP_FINISH: res_r.status <= ST_OK;
              OP_READ:   res_r.status <= idx_in_use ? ST_OK : ST_BAD_IDX;
              default:   res_r.status <= ST_OK;
            endcase
            if (op_t'(in_ch.op) == OP_READ && idx_in_use) begin
              res_r.completed_count <= done_cnt_r[in_ch.task_index];
              res_r.missed_count    <= miss_cnt_r[in_ch.task_index];
              res_r.killed_count    <= kill_cnt_r[in_ch.task_index];
            end else begin
              res_r.completed_count <= '0;
              res_r.missed_count    <= '0;
              res_r.killed_count    <= '0;
            end
          end
        end
        S_DIV: begin
          if (rem_rsp.done) begin
            period_r[tidx_r]   <= per_r;
            reldl_r[tidx_r]    <= dl_r;
            burst_r[tidx_r]    <= bu_r;
            phase_r[tidx_r]    <= rem_rsp.rem;
            work_r[tidx_r]     <= '0;
            absdl_r[tidx_r]    <= '0;
            done_cnt_r[tidx_r] <= '0;
            miss_cnt_r[tidx_r] <= '0;
            kill_cnt_r[tidx_r] <= '0;
          end
        end
        S_TICK_SCAN: begin
          idx_r <= idx_r + IDX_W'(1);
          // phase tracks time mod period on every entry with a period, in use or not
          if (period_r[idx_r] != '0)
            phase_r[idx_r] <= (s_phase_inc == {1'b0, period_r[idx_r]}) ? '0 :
                              s_phase_inc[VAL_W-1:0];
          if (scan_in_use) begin
            work_r[idx_r]  <= s_work;
            absdl_r[idx_r] <= s_abs;
          end
          if (s_miss) begin
            miss_cnt_r[idx_r] <= sat_inc(miss_cnt_r[idx_r]);
            misses_r          <= misses_r + NUM_W'(1);
          end
          if (scan_in_use && s_work != '0 && (!best_vld_r || s_key < best_key_r)) begin
            best_vld_r  <= 1'b1;
            best_idx_r  <= idx_r;
            best_key_r  <= s_key;
            best_work_r <= s_work;
          end
        end
        S_PICK: begin
          time_r           <= time_r + TICK_BITS'(1);
          res_r.misses_now <= misses_r;
          if (best_vld_r) begin
            work_r[best_idx_r] <= best_work_r - VAL_W'(1);
            res_r.ran_valid    <= 1'b1;
            res_r.ran_task     <= best_idx_r;
            if (best_work_r == VAL_W'(1)) begin
              done_cnt_r[best_idx_r] <= sat_inc(done_cnt_r[best_idx_r]);
              res_r.job_done         <= 1'b1;
            end
          end
        end
        S_FIN_SCAN: begin
          idx_r          <= idx_r + IDX_W'(1);
          phase_r[idx_r] <= '0;
          if (scan_in_use && work_r[idx_r] != '0) begin
            work_r[idx_r] <= '0;
            if (absdl_r[idx_r] <= {1'b0, time_r}) begin
              miss_cnt_r[idx_r] <= sat_inc(miss_cnt_r[idx_r]);
              misses_r          <= misses_r + NUM_W'(1);
            end else begin
              kill_cnt_r[idx_r] <= sat_inc(kill_cnt_r[idx_r]);
            end
          end
          if (scan_last) begin
            time_r <= '0;
            if (scan_in_use && work_r[idx_r] != '0 && absdl_r[idx_r] <= {1'b0, time_r})
              res_r.misses_now <= misses_r + NUM_W'(1);
            else
              res_r.misses_now <= misses_r;
          end
        end
        S_OUT: if (out_free) out_res_r <= res_r;
        default: ;
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_res_r.status;
  assign out_ch.ran_valid       = out_res_r.ran_valid;
  assign out_ch.ran_task        = out_res_r.ran_task;
  assign out_ch.job_done        = out_res_r.job_done;
  assign out_ch.misses_now      = out_res_r.misses_now;
  assign out_ch.completed_count = out_res_r.completed_count;
  assign out_ch.missed_count    = out_res_r.missed_count;
  assign out_ch.killed_count    = out_res_r.killed_count;
endmodule

### test/tb_rm_edf_task_scheduler.sv
// self-checking testbench of the rate monotonic / edf task scheduler
module tb_rm_edf_task_scheduler;
  import rmedf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    op_t         op;
    logic [3:0]  idx;
    logic [15:0] per;
    logic [15:0] dl;
    logic [15:0] bu;
  } sched_op_t;

  typedef struct {
    status_t     status;
    logic        ran_valid;
    logic [3:0]  ran_task;
    logic        job_done;
    logic [4:0]  misses_now;
    logic [15:0] done_cnt;
    logic [15:0] miss_cnt;
    logic [15:0] kill_cnt;
  } sched_res_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [4:0] cfg_wdata;

  rmedf_in_if  in_ch();
  rmedf_out_if out_ch();

  rm_edf_task_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // scheduler state mirrored by the predictor
  logic        mode_edf;
  logic [4:0]  num_tasks;
  logic [15:0] period_of   [16];
  logic [15:0] rel_dl_of   [16];
  logic [15:0] burst_of    [16];
  logic [15:0] units_left  [16];
  logic [31:0] abs_dl_of   [16];
  logic [15:0] done_jobs   [16];
  logic [15:0] missed_jobs [16];
  logic [15:0] killed_jobs [16];
  logic        loaded      [16];
  logic [31:0] now_tick;

  sched_res_t pending_res[$];
  int errors;
  bit hold_req;
  int stall_left;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic int active_tasks();
    return (num_tasks > 16) ? 16 : int'(num_tasks);
  endfunction

  function automatic logic [15:0] sat16(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic sched_res_t schedule_step(sched_op_t it);
    sched_res_t r;
    int n;
    int pick;
    int misses;
    logic [31:0] d;
    r = '{status: ST_OK, default: '0};
    n = active_tasks();
    pick = -1;
    misses = 0;
    case (it.op)
      OP_LOAD, OP_READ: begin
        if (int'(it.idx) >= n) begin
          r.status = ST_BAD_IDX;
        end else if (it.op == OP_READ) begin
          r.done_cnt = done_jobs[it.idx];
          r.miss_cnt = missed_jobs[it.idx];
          r.kill_cnt = killed_jobs[it.idx];
        end else if (it.per == 0 || it.dl == 0 || it.bu == 0 || it.dl > it.per ||
                     it.bu > it.dl) begin
          r.status = ST_INVALID;
        end else begin
          period_of[it.idx] = it.per;
          rel_dl_of[it.idx] = it.dl;
          burst_of[it.idx] = it.bu;
          units_left[it.idx] = 0;
          abs_dl_of[it.idx] = 0;
          done_jobs[it.idx] = 0;
          missed_jobs[it.idx] = 0;
          killed_jobs[it.idx] = 0;
          loaded[it.idx] = 1'b1;
        end
      end
      OP_FINISH: begin
        for (int i = 0; i < n; i++) begin
          if (units_left[i] != 0) begin
            if (abs_dl_of[i] <= now_tick) begin
              missed_jobs[i] = sat16(missed_jobs[i]);
              misses++;
            end else begin
              killed_jobs[i] = sat16(killed_jobs[i]);
            end
            units_left[i] = 0;
          end
        end
        now_tick = 0;
        r.misses_now = (misses > 31) ? 5'd31 : 5'(misses);
      end
      default: begin
        if (now_tick >= 32'hFFFF) begin
          r.status = ST_OVERFLOW;
        end else begin
          for (int i = 0; i < n; i++) begin
            if (units_left[i] != 0 && abs_dl_of[i] == now_tick) begin
              missed_jobs[i] = sat16(missed_jobs[i]);
              units_left[i] = 0;
              misses++;
            end
          end
          for (int i = 0; i < n; i++) begin
            if (period_of[i] != 0 && (now_tick % period_of[i]) == 0) begin
              d = now_tick + rel_dl_of[i];
              units_left[i] = burst_of[i];
              abs_dl_of[i] = d;
            end
          end
          for (int i = 0; i < n; i++) begin
            if (units_left[i] != 0) begin
              if (pick < 0) pick = i;
              else if (!mode_edf && period_of[i] < period_of[pick]) pick = i;
              else if (mode_edf && abs_dl_of[i] < abs_dl_of[pick]) pick = i;
            end
          end
          if (pick >= 0) begin
            units_left[pick]--;
            r.ran_valid = 1'b1;
            r.ran_task = 4'(pick);
            if (units_left[pick] == 0) begin
              done_jobs[pick] = sat16(done_jobs[pick]);
              r.job_done = 1'b1;
            end
          end
          r.misses_now = (misses > 31) ? 5'd31 : 5'(misses);
          now_tick++;
        end
      end
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one operation, wait for the transfer, record what must come back
  task automatic send_op(sched_op_t it);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.op <= it.op;
    in_ch.task_index <= it.idx;
    in_ch.task_period <= it.per;
    in_ch.task_deadline <= it.dl;
    in_ch.task_burst <= it.bu;
    do @(posedge clk); while (!in_ch.ready);
    pending_res.push_back(schedule_step(it));
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send(op_t op, int idx = 0, int per = 0, int dl = 0, int bu = 0);
    sched_op_t it;
    it = '{op: op, idx: 4'(idx), per: 16'(per), dl: 16'(dl), bu: 16'(bu)};
    send_op(it);
  endtask

  task automatic drain();
    @(posedge clk);
    in_ch.valid <= 1'b0;
    wait (pending_res.size() == 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 5'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_POLICY) mode_edf = val[0];
    else num_tasks = 5'(val);
  endtask

  function automatic sched_op_t valid_load(int idx);
    sched_op_t it;
    it.op = OP_LOAD;
    it.idx = 4'(idx);
    it.per = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(1, 24)) :
                                          16'($urandom_range(1, 65535));
    it.dl = 16'($urandom_range(1, it.per));
    it.bu = 16'($urandom_range(1, it.dl));
    return it;
  endfunction

  task automatic load_all();
    for (int i = 0; i < active_tasks(); i++) send_op(valid_load(i));
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // receiver: random stalls, long holds on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      stall_left = 400;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      int p;
      p = $urandom_range(0, 99);
      if (p < 3) stall_left = $urandom_range(10, 50);
      else if (p < 25) stall_left = $urandom_range(0, 2);
      out_ch.ready <= (p >= 25);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_res.size() == 0) begin
        errors++;
        $display("result transfer with nothing expected at %0t", $realtime);
      end else begin
        sched_res_t e;
        e = pending_res.pop_front();
        if (out_ch.status != e.status) report("status", out_ch.status, e.status);
        if (out_ch.ran_valid != e.ran_valid) report("ran_valid", out_ch.ran_valid, e.ran_valid);
        if (out_ch.ran_task != e.ran_task) report("ran_task", out_ch.ran_task, e.ran_task);
        if (out_ch.job_done != e.job_done) report("job_done", out_ch.job_done, e.job_done);
        if (out_ch.misses_now != e.misses_now)
          report("misses_now", out_ch.misses_now, e.misses_now);
        if (out_ch.completed_count != e.done_cnt)
          report("completed_count", out_ch.completed_count, e.done_cnt);
        if (out_ch.missed_count != e.miss_cnt)
          report("missed_count", out_ch.missed_count, e.miss_cnt);
        if (out_ch.killed_count != e.kill_cnt)
          report("killed_count", out_ch.killed_count, e.kill_cnt);
      end
    end
  end

  task automatic test_directed();
    write_reg(CFG_COUNT, 3);
    send(OP_LOAD, 0, 0, 1, 1);
    send(OP_LOAD, 0, 4, 0, 1);
    send(OP_LOAD, 0, 4, 2, 0);
    send(OP_LOAD, 0, 4, 5, 1);
    send(OP_LOAD, 0, 4, 2, 3);
    send(OP_LOAD, 15, 4, 2, 1);
    send(OP_READ, 3);
    send(OP_LOAD, 0, 4, 3, 2);
    send(OP_LOAD, 1, 6, 6, 3);
    send(OP_LOAD, 2, 65535, 65535, 65535);
    for (int i = 0; i < 10; i++) send(OP_TICK);
    send(OP_READ, 0);
    send(OP_READ, 2);
    send(OP_FINISH);
    send(OP_READ, 1);
    send(OP_READ, 2);
  endtask

  task automatic test_edf_and_count_edges();
    write_reg(CFG_POLICY, 1);
    write_reg(CFG_COUNT, 0);
    send(OP_TICK);
    send(OP_LOAD, 0, 3, 2, 1);
    send(OP_READ, 0);
    send(OP_FINISH);
    write_reg(CFG_COUNT, 31);
    load_all();
    for (int i = 0; i < 40; i++) send(OP_TICK);
    send(OP_READ, 15);
    send(OP_FINISH);
  endtask

  task automatic test_random(int items);
    sched_op_t it;
    int p;
    for (int k = 0; k < items; k++) begin
      it = '{op: OP_TICK, default: '0};
      p = $urandom_range(0, 99);
      if (p < 12) begin
        if (p < 6) it = valid_load($urandom_range(0, 15));
        else it = '{op: OP_LOAD, idx: 4'($urandom), per: 16'($urandom), dl: 16'($urandom),
                    bu: 16'($urandom)};
      end else if (p < 24) begin
        it.op = OP_READ;
        it.idx = 4'($urandom_range(0, 15));
      end else if (p < 28) begin
        it.op = OP_FINISH;
      end
      // never tick with an entry in use that holds no task
      if (it.op == OP_TICK)
        for (int i = active_tasks() - 1; i >= 0; i--)
          if (!loaded[i]) it = valid_load(i);
      send_op(it);
    end
  endtask

  task automatic test_random_phases();
    int counts[6] = '{1, 2, 4, 7, 16, 20};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_POLICY, ph % 2);
      write_reg(CFG_COUNT, counts[ph]);
      load_all();
      test_random(75);
    end
  endtask

  task automatic test_backpressure();
    write_reg(CFG_COUNT, 4);
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) send(OP_TICK);
    drain();
    for (int i = 0; i < 10; i++) send(OP_TICK);
    send(OP_FINISH);
  endtask

  initial begin
    errors = 0;
    hold_req = 1'b0;
    stall_left = 0;
    mode_edf = 1'b0;
    num_tasks = 5'd1;
    now_tick = 0;
    for (int i = 0; i < 16; i++) begin
      period_of[i] = 0;
      rel_dl_of[i] = 0;
      burst_of[i] = 0;
      units_left[i] = 0;
      abs_dl_of[i] = 0;
      done_jobs[i] = 0;
      missed_jobs[i] = 0;
      killed_jobs[i] = 0;
      loaded[i] = 1'b0;
    end
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_POLICY;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_LOAD;
    in_ch.task_index = '0;
    in_ch.task_period = '0;
    in_ch.task_deadline = '0;
    in_ch.task_burst = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_edf_and_count_edges();
    test_random_phases();
    test_backpressure();

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0 && pending_res.size() == 0) begin
      $display("** rm_edf_task_scheduler: PASSED **");
    end else begin
      $display("** rm_edf_task_scheduler: FAILED **");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout waiting for transfers");
    $display("** rm_edf_task_scheduler: FAILED **");
    $finish;
  end

endmodule

### files.f
rtl/core/rmedf_pkg.sv
rtl/core/rmedf_in_if.sv
rtl/core/rmedf_out_if.sv
rtl/core/rmedf_rem.sv
rtl/core/rm_edf_task_scheduler.sv
test/tb_rm_edf_task_scheduler.sv
